// ===== rtl/core/averaging_flash_ring_logger_core_assert.svh =====
// Assertion macros used by the logger core.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef AVERAGING_FLASH_RING_LOGGER_CORE_ASSERT_SVH
`define AVERAGING_FLASH_RING_LOGGER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define AFLR_ASSERT_HOLDS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("logger invariant violated");
`define AFLR_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("logger implication violated");
`define AFLR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("logger sequence violated");
`else
`define AFLR_ASSERT_HOLDS(label, cond)
`define AFLR_ASSERT_IMPLIES(label, ante, cons)
`define AFLR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/core/aflr_pkg.sv =====
`default_nettype none
package aflr_pkg;

	// Flash geometry
	localparam int SECTOR_BYTES       = 4096;
	localparam int RECORD_BYTES       = 10;
	localparam int HEADER_BYTES       = 6;
	localparam int RECORDS_PER_SECTOR = 409;
	localparam int SECTOR_SHIFT       = $clog2(SECTOR_BYTES);

	// Field widths
	localparam int VAL_W      = 16;
	localparam int TIME_W     = 32;
	localparam int SUM_W      = 32;
	localparam int ADDR_W     = 24;
	localparam int WIDE_W     = 32;
	localparam int AVG_W      = 8;
	localparam int SEC_W      = 12;
	localparam int SEC_END_W  = 13;
	localparam int MAGIC_W    = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 104;
	localparam int RIS_W      = $clog2(RECORDS_PER_SECTOR);
	localparam int DIV_CNT_W  = $clog2(SUM_W);

	// Reset values of the registers
	localparam int AVG_RESET   = 1;
	localparam int FIRST_RESET = 64;
	localparam int END_RESET   = 116;
	localparam int MAGIC_RESET = 0;
	localparam logic [ADDR_W-1:0] WADDR_RESET =
		ADDR_W'(FIRST_RESET * SECTOR_BYTES + HEADER_BYTES);

	// Unknown time is stored one below all ones
	localparam logic [TIME_W-1:0] TIME_UNKNOWN  = '1;
	localparam logic [TIME_W-1:0] TIME_REPLACED = TIME_UNKNOWN - TIME_W'(1);

	typedef enum logic [1:0] {
		OP_WRITE_RECORD = 2'd0,
		OP_CLOSE_FLAG   = 2'd1,
		OP_ERASE_SECTOR = 2'd2,
		OP_WRITE_ID     = 2'd3
	} flash_op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AVG_COUNT    = 2'd0,
		REG_FIRST_SECTOR = 2'd1,
		REG_END_SECTOR   = 2'd2,
		REG_SECTOR_MAGIC = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_EMIT
	} state_t;

	// Control of the bit-serial divider lanes
	typedef struct packed {
		logic load;
		logic step;
	} div_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/averaging_flash_ring_logger_core.sv =====
`default_nettype none
// Averaging flash ring logger.
// s_axis carries one sensor sample per request; m_axis carries flash operations
// (record write, close flag, sector erase, sector id write), tlast on the final
// operation caused by a sample. cfg_we/cfg_index/cfg_wdata write the averaging
// count, region bounds and sector id word; write them only while idle.
// A sample taken with avg_count of 1 is logged directly as 1 or 4 operations,
// one per cycle while m_axis_tready allows. Otherwise the sample is summed; a
// sample that does not complete a record (or arrives with radio_busy) is
// accepted and yields nothing. A completing sample runs the three bit-serial
// dividers, one quotient bit per cycle, and its record is then emitted.
// The next sample is taken once the last operation sits in the output register.
// Reset clears the sums and counts, loads the register defaults and points the
// write address just past the header of the default first sector.
// When m_axis_tready is low, the output register holds and emission waits;
// s_axis_tready stays low until every operation of the sample is in the output register.
module averaging_flash_ring_logger_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// primary_value, signed_value, third_value, timestamp
	input  wire logic [aflr_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// radio_busy
	input  wire logic [0:0]                          s_axis_tuser,
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// flash_address, rec_time, rec_primary, rec_signed, rec_third
	output logic      [aflr_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	// flash_op
	output logic      [1:0]                          m_axis_tuser,
	output logic                                     m_axis_tlast,
	input  wire logic                                cfg_we,
	input  wire logic [aflr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [aflr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	`include "averaging_flash_ring_logger_core_assert.svh"

	localparam int VAL_W     = aflr_pkg::VAL_W;
	localparam int TIME_W    = aflr_pkg::TIME_W;
	localparam int SUM_W     = aflr_pkg::SUM_W;
	localparam int ADDR_W    = aflr_pkg::ADDR_W;
	localparam int WIDE_W    = aflr_pkg::WIDE_W;
	localparam int AVG_W     = aflr_pkg::AVG_W;
	localparam int SEC_W     = aflr_pkg::SEC_W;
	localparam int SEC_END_W = aflr_pkg::SEC_END_W;
	localparam int MAGIC_W   = aflr_pkg::MAGIC_W;
	localparam int RIS_W     = aflr_pkg::RIS_W;
	localparam int DIV_CNT_W = aflr_pkg::DIV_CNT_W;
	localparam int SHIFT     = aflr_pkg::SECTOR_SHIFT;

	// Configuration
	logic [AVG_W-1:0]     avg_q;
	logic [SEC_W-1:0]     first_q;
	logic [SEC_END_W-1:0] end_q;
	logic [MAGIC_W-1:0]   magic_q;

	// Averaging and ring state
	logic [SUM_W-1:0]  sum_p_q, sum_s_q, sum_t_q, cnt_q;
	logic [ADDR_W-1:0] wa_q;
	logic [RIS_W-1:0]  records_q;

	aflr_pkg::state_t     state_q, state_d;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	aflr_pkg::flash_op_t  idx_q;

	// Held request
	logic [TIME_W-1:0] ts_q;
	logic [VAL_W-1:0]  rec_p_q, rec_s_q, rec_t_q;
	logic              avg_rec_q;
	logic              neg_q;

	// Output register
	logic                out_valid_q;
	aflr_pkg::flash_op_t out_op_q;
	logic [ADDR_W-1:0]   out_addr_q;
	logic [TIME_W-1:0]   out_time_q;
	logic [VAL_W-1:0]    out_p_q, out_s_q, out_t_q;
	logic                out_last_q;

	// Request fields
	logic [VAL_W-1:0]  in_p, in_s, in_t;
	logic [TIME_W-1:0] in_ts;
	logic              in_busy;

	logic              accept;
	logic              direct;
	logic              defer;
	logic [SUM_W-1:0]  sum_p_nx, sum_s_nx, sum_t_nx, cnt_nx;
	logic [SUM_W-1:0]  mag_num, mag_den;

	aflr_pkg::div_ctl_t div_ctl;
	logic [VAL_W-1:0]   quo_p, quo_s, quo_t;
	logic [VAL_W-1:0]   fin_p, fin_s, fin_t;

	logic              div_last;
	logic              out_load;
	logic              out_last;
	logic              close;
	logic [WIDE_W-1:0] addr_x, next_rec_x, base_x, nxt_x, start_x, end_x, sel_x;
	logic [ADDR_W-1:0] nxt_addr, close_addr, wa_nx;
	logic [ADDR_W-1:0] em_addr;
	logic [TIME_W-1:0] em_time;
	logic [VAL_W-1:0]  em_p, em_s, em_t;

	// Unpack the request
	assign in_p    = s_axis_tdata[15:0];
	assign in_s    = s_axis_tdata[31:16];
	assign in_t    = s_axis_tdata[47:32];
	assign in_ts   = s_axis_tdata[79:48];
	assign in_busy = s_axis_tuser[0];

	// Running sums with the new sample
	always_comb begin
		sum_p_nx = sum_p_q + SUM_W'(in_p);
		sum_s_nx = sum_s_q + {{(SUM_W-VAL_W){in_s[VAL_W-1]}}, in_s};
		sum_t_nx = sum_t_q + SUM_W'(in_t);
		cnt_nx   = (&cnt_q) ? cnt_q : cnt_q + SUM_W'(1);
		direct   = avg_q == AVG_W'(aflr_pkg::AVG_RESET);
		defer    = (SUM_W'(avg_q) > cnt_nx) || in_busy;
		mag_num  = sum_s_nx[SUM_W-1] ? -sum_s_nx : sum_s_nx;
		mag_den  = cnt_nx[SUM_W-1] ? -cnt_nx : cnt_nx;
	end

	// Ring addressing for the pending record
	always_comb begin
		addr_x     = WIDE_W'(wa_q);
		next_rec_x = addr_x + WIDE_W'(aflr_pkg::RECORD_BYTES);
		close      = (records_q >= RIS_W'(aflr_pkg::RECORDS_PER_SECTOR - 1))
			|| (next_rec_x[WIDE_W-1:SHIFT] != addr_x[WIDE_W-1:SHIFT]);
		base_x     = addr_x & ~WIDE_W'(aflr_pkg::SECTOR_BYTES - 1);
		nxt_x      = base_x + WIDE_W'(aflr_pkg::SECTOR_BYTES);
		start_x    = WIDE_W'(first_q) << SHIFT;
		end_x      = WIDE_W'(end_q) << SHIFT;
		if (nxt_x >= end_x) begin
			sel_x = start_x;
		end else if (nxt_x < start_x) begin
			sel_x = end_x - WIDE_W'(aflr_pkg::SECTOR_BYTES);
		end else begin
			sel_x = nxt_x;
		end
		nxt_addr   = sel_x[ADDR_W-1:0] & ~ADDR_W'(aflr_pkg::SECTOR_BYTES - 1);
		close_addr = base_x[ADDR_W-1:0] + ADDR_W'(aflr_pkg::HEADER_BYTES - 2);
		wa_nx      = close ? nxt_addr + ADDR_W'(aflr_pkg::HEADER_BYTES)
			: next_rec_x[ADDR_W-1:0];
	end

	// Record values: divider quotients for averaged records
	always_comb begin
		fin_p = avg_rec_q ? quo_p : rec_p_q;
		fin_s = avg_rec_q ? (neg_q ? -quo_s : quo_s) : rec_s_q;
		fin_t = avg_rec_q ? quo_t : rec_t_q;
	end

	// Select the fields of the current operation
	always_comb begin
		em_addr = nxt_addr;
		em_time = '0;
		em_p    = '0;
		em_s    = '0;
		em_t    = '0;
		case (idx_q)
			aflr_pkg::OP_WRITE_RECORD: begin
				em_addr = wa_q;
				em_time = ts_q;
				em_p    = fin_p;
				em_s    = fin_s;
				em_t    = fin_t;
			end
			aflr_pkg::OP_CLOSE_FLAG: begin
				em_addr = close_addr;
			end
			aflr_pkg::OP_ERASE_SECTOR: begin
				em_addr = nxt_addr;
			end
			aflr_pkg::OP_WRITE_ID: begin
				em_addr = nxt_addr;
				em_time = magic_q;
			end
			default: begin
				em_addr = nxt_addr;
			end
		endcase
		out_last = close ? (idx_q == aflr_pkg::OP_WRITE_ID)
			: (idx_q == aflr_pkg::OP_WRITE_RECORD);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			aflr_pkg::ST_IDLE: begin
				if (s_axis_tvalid) begin
					if (direct) begin
						state_d = aflr_pkg::ST_EMIT;
					end else if (!defer) begin
						state_d = aflr_pkg::ST_DIVIDE;
					end
				end
			end
			aflr_pkg::ST_DIVIDE: begin
				if (div_last) begin
					state_d = aflr_pkg::ST_EMIT;
				end
			end
			aflr_pkg::ST_EMIT: begin
				if ((!out_valid_q || m_axis_tready) && out_last) begin
					state_d = aflr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = aflr_pkg::ST_IDLE;
			end
		endcase
	end

	// Handshake and divider control
	always_comb begin
		s_axis_tready = state_q == aflr_pkg::ST_IDLE;
		accept        = s_axis_tvalid && s_axis_tready;
		div_last      = div_cnt_q == DIV_CNT_W'(SUM_W - 1);
		div_ctl.load  = accept && !direct && !defer;
		div_ctl.step  = state_q == aflr_pkg::ST_DIVIDE;
		out_load      = (state_q == aflr_pkg::ST_EMIT) && (!out_valid_q || m_axis_tready);
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q   <= AVG_W'(aflr_pkg::AVG_RESET);
			first_q <= SEC_W'(aflr_pkg::FIRST_RESET);
			end_q   <= SEC_END_W'(aflr_pkg::END_RESET);
			magic_q <= MAGIC_W'(aflr_pkg::MAGIC_RESET);
		end else if (cfg_we) begin
			case (aflr_pkg::cfg_reg_t'(cfg_index))
				aflr_pkg::REG_AVG_COUNT:    avg_q   <= cfg_wdata[AVG_W-1:0];
				aflr_pkg::REG_FIRST_SECTOR: first_q <= cfg_wdata[SEC_W-1:0];
				aflr_pkg::REG_END_SECTOR:   end_q   <= cfg_wdata[SEC_END_W-1:0];
				aflr_pkg::REG_SECTOR_MAGIC: magic_q <= cfg_wdata[MAGIC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer, sums and ring position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= aflr_pkg::ST_IDLE;
			div_cnt_q   <= '0;
			idx_q       <= aflr_pkg::OP_WRITE_RECORD;
			out_valid_q <= 1'b0;
			sum_p_q     <= '0;
			sum_s_q     <= '0;
			sum_t_q     <= '0;
			cnt_q       <= '0;
			wa_q        <= aflr_pkg::WADDR_RESET;
			records_q   <= '0;
		end else begin
			state_q <= state_d;
			// Accumulate or clear the sums
			if (accept && !direct) begin
				if (defer) begin
					sum_p_q <= sum_p_nx;
					sum_s_q <= sum_s_nx;
					sum_t_q <= sum_t_nx;
					cnt_q   <= cnt_nx;
				end else begin
					sum_p_q <= '0;
					sum_s_q <= '0;
					sum_t_q <= '0;
					cnt_q   <= '0;
				end
			end
			// Count divider steps
			if (div_ctl.load) begin
				div_cnt_q <= '0;
			end else if (div_ctl.step) begin
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			end
			// Advance through the operations of the request
			if (out_load) begin
				idx_q <= out_last ? aflr_pkg::OP_WRITE_RECORD
					: aflr_pkg::flash_op_t'(idx_q + 2'd1);
				if (out_last) begin
					wa_q      <= wa_nx;
					records_q <= close ? '0 : records_q + RIS_W'(1);
				end
			end
			// Output register valid
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the request payload
	always_ff @(posedge clk) begin
		if (accept) begin
			ts_q      <= (in_ts == aflr_pkg::TIME_UNKNOWN) ? aflr_pkg::TIME_REPLACED : in_ts;
			rec_p_q   <= in_p;
			rec_s_q   <= in_s;
			rec_t_q   <= in_t;
			avg_rec_q <= !direct;
			neg_q     <= sum_s_nx[SUM_W-1] ^ cnt_nx[SUM_W-1];
		end
	end

	// Load the output register
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_op_q   <= idx_q;
			out_addr_q <= em_addr;
			out_time_q <= em_time;
			out_p_q    <= em_p;
			out_s_q    <= em_s;
			out_t_q    <= em_t;
			out_last_q <= out_last;
		end
	end

	// Bit-serial dividers: unsigned primary, signed magnitude, unsigned third
	aflr_div_lane u_div_p (
		.clk      (clk),
		.ctl      (div_ctl),
		.dividend (sum_p_nx),
		.divisor  (cnt_nx),
		.quotient (quo_p)
	);

	aflr_div_lane u_div_s (
		.clk      (clk),
		.ctl      (div_ctl),
		.dividend (mag_num),
		.divisor  (mag_den),
		.quotient (quo_s)
	);

	aflr_div_lane u_div_t (
		.clk      (clk),
		.ctl      (div_ctl),
		.dividend (sum_t_nx),
		.divisor  (cnt_nx),
		.quotient (quo_t)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_t_q, out_s_q, out_p_q, out_time_q, out_addr_q};
	assign m_axis_tuser  = out_op_q;
	assign m_axis_tlast  = out_last_q;

	`AFLR_ASSERT_HOLDS(a_records_bound, records_q <= RIS_W'(aflr_pkg::RECORDS_PER_SECTOR - 1))
	`AFLR_ASSERT_HOLDS(a_addr_past_header, wa_q[SHIFT-1:0] >= SHIFT'(aflr_pkg::HEADER_BYTES))
	`AFLR_ASSERT_IMPLIES(a_open_sector_single, (state_q == aflr_pkg::ST_EMIT) && !close, idx_q == aflr_pkg::OP_WRITE_RECORD)
	`AFLR_ASSERT_NEXT(a_last_returns_idle, out_load && out_last, state_q == aflr_pkg::ST_IDLE)

endmodule
`default_nettype wire

// ===== rtl/core/aflr_div_lane.sv =====
`default_nettype none
// Restoring divider, one quotient bit per step; keeps the low quotient bits.
module aflr_div_lane (
	input  wire logic                          clk,
	input  wire aflr_pkg::div_ctl_t            ctl,
	input  wire logic [aflr_pkg::SUM_W-1:0]    dividend,
	input  wire logic [aflr_pkg::SUM_W-1:0]    divisor,
	output logic      [aflr_pkg::VAL_W-1:0]    quotient
);

	localparam int SUM_W = aflr_pkg::SUM_W;
	localparam int VAL_W = aflr_pkg::VAL_W;

	logic [SUM_W-1:0] dvd_q;
	logic [SUM_W-1:0] dsr_q;
	logic [SUM_W-1:0] rem_q;
	logic [VAL_W-1:0] quo_q;
	logic [SUM_W:0]   rem_sh;
	logic [SUM_W:0]   rem_sub;
	logic             fits;

	// Bring down the next dividend bit and trial-subtract
	always_comb begin
		rem_sh  = {rem_q, dvd_q[SUM_W-1]};
		fits    = rem_sh >= {1'b0, dsr_q};
		rem_sub = rem_sh - {1'b0, dsr_q};
	end

	// Load operands or advance one bit
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (ctl.step) begin
			dvd_q <= {dvd_q[SUM_W-2:0], 1'b0};
			rem_q <= fits ? rem_sub[SUM_W-1:0] : rem_sh[SUM_W-1:0];
			quo_q <= {quo_q[VAL_W-2:0], fits};
		end
	end

	assign quotient = quo_q;

endmodule
`default_nettype wire

// ===== sim/flash_log_monitor.sv =====
`default_nettype none
// Watch the sample stream, the config port and the flash request stream of the logger.
// Keep a private copy of the logger state and queue the flash requests each sample
// should cause, then compare every flash request against the oldest queued one.
module flash_log_monitor
	import aflr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	input  wire logic                  s_axis_tready,
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  wire logic [0:0]            s_axis_tuser,
	input  wire logic                  m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	input  wire logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  wire logic [1:0]            m_axis_tuser,
	input  wire logic                  m_axis_tlast,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output int                         mismatches,
	output int                         outstanding
);

	typedef struct {
		flash_op_t         op;
		logic [ADDR_W-1:0] addr;
		logic [TIME_W-1:0] stamp;
		logic [VAL_W-1:0]  primary;
		logic [VAL_W-1:0]  sval;
		logic [VAL_W-1:0]  third;
		logic              last;
	} flash_req_t;

	flash_req_t queued_reqs[$];

	// Register copies
	logic [AVG_W-1:0]     avg_cnt;
	logic [SEC_W-1:0]     first_sec;
	logic [SEC_END_W-1:0] end_sec;
	logic [MAGIC_W-1:0]   magic;

	// Logger state copies
	logic [SUM_W-1:0]  sum_p;
	logic [SUM_W-1:0]  sum_s;
	logic [SUM_W-1:0]  sum_t;
	logic [SUM_W-1:0]  n_samples;
	logic [ADDR_W-1:0] wr_addr;
	logic [RIS_W-1:0]  in_sector;
	int                req_idx;

	function automatic logic [31:0] sector_base(input logic [31:0] a);
		return (a / 32'(SECTOR_BYTES)) * 32'(SECTOR_BYTES);
	endfunction

	task automatic queue_req(input flash_op_t op, input logic [31:0] a, input logic [31:0] stamp,
			input logic [31:0] pv, input logic [31:0] sv, input logic [31:0] tv, input logic last);
		flash_req_t r;
		r.op      = op;
		r.addr    = a[ADDR_W-1:0];
		r.stamp   = stamp;
		r.primary = pv[VAL_W-1:0];
		r.sval    = sv[VAL_W-1:0];
		r.third   = tv[VAL_W-1:0];
		r.last    = last;
		queued_reqs.push_back(r);
	endtask

	// Accumulate one sample and queue the flash requests it causes
	task automatic log_sample(input logic [VAL_W-1:0] p, input logic [VAL_W-1:0] s,
			input logic [VAL_W-1:0] th, input logic [TIME_W-1:0] ts, input logic busy);
		logic [31:0]        rp;
		logic [31:0]        rs;
		logic [31:0]        rt;
		logic [31:0]        stamp;
		logic [31:0]        addr;
		logic [31:0]        base;
		logic [31:0]        nxt;
		logic [31:0]        start_a;
		logic [31:0]        end_a;
		logic [ADDR_W-1:0]  nxt_wrapped;
		logic signed [31:0] quot;
		logic               take;
		take = 1'b1;
		rp = 32'(p);
		rs = 32'(s);
		rt = 32'(th);
		if (avg_cnt != AVG_W'(1)) begin
			sum_p = sum_p + 32'(p);
			sum_s = sum_s + {{(SUM_W-VAL_W){s[VAL_W-1]}}, s};
			sum_t = sum_t + 32'(th);
			if (n_samples != '1)
				n_samples = n_samples + 1;
			// hold the sums until enough samples are in and the radio is quiet
			if (32'(avg_cnt) > n_samples || busy) begin
				take = 1'b0;
			end else begin
				rp = sum_p / n_samples;
				quot = $signed(sum_s) / $signed(n_samples);
				rs = quot;
				rt = sum_t / n_samples;
				sum_p = '0;
				sum_s = '0;
				sum_t = '0;
				n_samples = '0;
			end
		end
		if (take) begin
			stamp = (ts == TIME_UNKNOWN) ? TIME_REPLACED : ts;
			addr = 32'(wr_addr);
			base = sector_base(addr);
			if (in_sector >= RIS_W'(RECORDS_PER_SECTOR - 1) ||
					base != sector_base(addr + RECORD_BYTES)) begin
				// close this sector and open the next one in the ring
				queue_req(OP_WRITE_RECORD, addr, stamp, rp, rs, rt, 1'b0);
				queue_req(OP_CLOSE_FLAG, base + HEADER_BYTES - 2, '0, '0, '0, '0, 1'b0);
				start_a = 32'(first_sec) * SECTOR_BYTES;
				end_a = 32'(end_sec) * SECTOR_BYTES;
				nxt = base + SECTOR_BYTES;
				if (nxt >= end_a)
					nxt = start_a;
				else if (nxt < start_a)
					nxt = end_a - SECTOR_BYTES;
				nxt_wrapped = nxt[ADDR_W-1:0];
				nxt = sector_base(32'(nxt_wrapped));
				queue_req(OP_ERASE_SECTOR, nxt, '0, '0, '0, '0, 1'b0);
				queue_req(OP_WRITE_ID, nxt, magic, '0, '0, '0, 1'b1);
				wr_addr = ADDR_W'(nxt + HEADER_BYTES);
				in_sector = '0;
			end else begin
				queue_req(OP_WRITE_RECORD, addr, stamp, rp, rs, rt, 1'b1);
				in_sector = in_sector + 1;
				wr_addr = ADDR_W'(addr + RECORD_BYTES);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		flash_req_t want;
		flash_req_t got;
		if (!arst_n) begin
			avg_cnt = AVG_W'(AVG_RESET);
			first_sec = SEC_W'(FIRST_RESET);
			end_sec = SEC_END_W'(END_RESET);
			magic = MAGIC_W'(MAGIC_RESET);
			sum_p = '0;
			sum_s = '0;
			sum_t = '0;
			n_samples = '0;
			wr_addr = ADDR_W'(FIRST_RESET * SECTOR_BYTES + HEADER_BYTES);
			in_sector = '0;
			req_idx = 0;
			mismatches = 0;
			queued_reqs.delete();
			outstanding <= 0;
		end else begin
			// compare a flash request against the oldest queued one
			if (m_axis_tvalid && m_axis_tready) begin
				got.op      = flash_op_t'(m_axis_tuser);
				got.addr    = m_axis_tdata[0 +: ADDR_W];
				got.stamp   = m_axis_tdata[ADDR_W +: TIME_W];
				got.primary = m_axis_tdata[ADDR_W+TIME_W +: VAL_W];
				got.sval    = m_axis_tdata[ADDR_W+TIME_W+VAL_W +: VAL_W];
				got.third   = m_axis_tdata[ADDR_W+TIME_W+2*VAL_W +: VAL_W];
				got.last    = m_axis_tlast;
				if (queued_reqs.size() == 0) begin
					if (mismatches < 10)
						$display("flash request %0d unexpected: op=%0d addr=%h time=%h p=%h s=%h t=%h last=%b",
							req_idx, got.op, got.addr, got.stamp, got.primary, got.sval,
							got.third, got.last);
					mismatches++;
				end else begin
					want = queued_reqs.pop_front();
					if (got.op !== want.op || got.addr !== want.addr || got.stamp !== want.stamp ||
							got.primary !== want.primary || got.sval !== want.sval ||
							got.third !== want.third || got.last !== want.last) begin
						if (mismatches < 10) begin
							$display("flash request %0d expected: op=%0d addr=%h time=%h p=%h s=%h t=%h last=%b",
								req_idx, want.op, want.addr, want.stamp, want.primary, want.sval,
								want.third, want.last);
							$display("flash request %0d actual:   op=%0d addr=%h time=%h p=%h s=%h t=%h last=%b",
								req_idx, got.op, got.addr, got.stamp, got.primary, got.sval,
								got.third, got.last);
						end
						mismatches++;
					end
				end
				req_idx++;
			end
			// track register writes
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_AVG_COUNT:    avg_cnt = cfg_wdata[AVG_W-1:0];
					REG_FIRST_SECTOR: first_sec = cfg_wdata[SEC_W-1:0];
					REG_END_SECTOR:   end_sec = cfg_wdata[SEC_END_W-1:0];
					REG_SECTOR_MAGIC: magic = cfg_wdata[MAGIC_W-1:0];
					default: ;
				endcase
			end
			// predict on each accepted sample request
			if (s_axis_tvalid && s_axis_tready)
				log_sample(s_axis_tdata[0 +: VAL_W], s_axis_tdata[VAL_W +: VAL_W],
					s_axis_tdata[2*VAL_W +: VAL_W], s_axis_tdata[3*VAL_W +: TIME_W],
					s_axis_tuser[0]);
			outstanding <= queued_reqs.size();
		end
	end

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`default_nettype none
module testbench;
	import aflr_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int LONG_HOLD    = 400;
	localparam int DRAIN_CYCLES = 48;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// primary_value, signed_value, third_value, timestamp
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	// radio_busy
	logic [0:0]            s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// flash_address, rec_time, rec_primary, rec_signed, rec_third
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	// flash_op
	logic [1:0]            m_axis_tuser;
	logic                  m_axis_tlast;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_AVG_COUNT;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	int   mismatches;
	int   outstanding;
	int   cycle_count = 0;
	int   gap_pct = 0;
	int   stall_pct = 0;
	logic hold_armed = 1'b0;

	always #6 clk = ~clk;

	averaging_flash_ring_logger_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	flash_log_monitor monitor (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Drive the flash side ready: one long hold when armed, else random stall bursts
	initial begin : flash_side
		bit hold_done = 1'b0;
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_armed && !hold_done) begin
				hold_done = 1'b1;
				m_axis_tready <= 1'b0;
				for (int c = 0; c < LONG_HOLD; c++)
					@(posedge clk);
			end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 16))
					@(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	function automatic logic [15:0] pick16();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			3: return 16'h7FFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// Offer one sample request, maybe after a gap, and wait for its acceptance
	task automatic send_sample(input logic [15:0] p, input logic [15:0] s, input logic [15:0] th,
			input logic [31:0] ts, input logic busy);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16))
				@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {ts, th, s, p};
		s_axis_tuser <= busy;
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	// Stop offering and wait until every flash request has come out
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic settle_and_configure(input logic [7:0] avg, input logic [11:0] first_sec,
			input logic [12:0] end_sec, input logic [31:0] magic);
		wait_drained();
		write_reg(REG_AVG_COUNT, 32'(avg));
		write_reg(REG_FIRST_SECTOR, 32'(first_sec));
		write_reg(REG_END_SECTOR, 32'(end_sec));
		write_reg(REG_SECTOR_MAGIC, magic);
		cfg_we <= 1'b0;
	endtask

	task automatic pick_idling();
		gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
		stall_pct = ($urandom_range(0, 2) == 0) ? 0 : 10;
	endtask

	task automatic run_random(input int count, input int busy_pct);
		logic [31:0] ts;
		for (int k = 0; k < count; k++) begin
			case ($urandom_range(0, 11))
				0: ts = 32'hFFFF_FFFF;
				1: ts = 32'hFFFF_FFFE;
				2: ts = 32'h0000_0000;
				default: ts = $urandom;
			endcase
			send_sample(pick16(), pick16(), pick16(), ts, $urandom_range(0, 99) < busy_pct);
		end
	endtask

	initial begin : stimulus
		logic [7:0] avg;
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		gap_pct = 25;
		stall_pct = 10;

		// direct logging with reset settings; busy has no effect here
		send_sample(16'h0000, 16'h0000, 16'h0000, 32'h0000_0000, 1'b0);
		send_sample(16'hFFFF, 16'h7FFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
		send_sample(16'h0001, 16'h8000, 16'h0001, 32'hFFFF_FFFE, 1'b0);
		send_sample(16'h8000, 16'hFFFF, 16'h7FFF, 32'h8000_0000, 1'b0);

		// averages of two: extremes, unknown time, truncation toward zero
		settle_and_configure(8'd2, 12'd64, 13'd116, 32'hA5C3_0F1E);
		send_sample(16'hFFFF, 16'h7FFF, 16'hFFFF, 32'h0000_0001, 1'b0);
		send_sample(16'hFFFF, 16'h7FFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
		send_sample(16'h0000, 16'h8000, 16'h0000, 32'h1234_5678, 1'b0);
		send_sample(16'h0000, 16'h8000, 16'h0000, 32'h1234_5679, 1'b0);
		send_sample(16'h0001, 16'hFFFF, 16'h0001, 32'h0000_0010, 1'b0);
		send_sample(16'h0000, 16'h0000, 16'h0000, 32'h0000_0011, 1'b0);
		send_sample(16'h0003, 16'hFFFD, 16'h0005, 32'h0000_0012, 1'b0);
		send_sample(16'h0000, 16'h0000, 16'h0000, 32'h0000_0013, 1'b0);
		// radio busy defers the record to the next quiet sample
		send_sample(16'd100, 16'h0010, 16'd7, 32'h0000_0020, 1'b0);
		send_sample(16'd200, 16'hFFF0, 16'd8, 32'h0000_0021, 1'b1);
		send_sample(16'd300, 16'hFF00, 16'd9, 32'h0000_0022, 1'b0);

		// count of zero: averaging path, busy still defers
		settle_and_configure(8'd0, 12'd64, 13'd116, 32'hFFFF_FFFF);
		send_sample(16'd1000, 16'h8001, 16'd10, 32'h0000_0030, 1'b1);
		send_sample(16'd2000, 16'h0123, 16'd20, 32'hFFFF_FFFF, 1'b1);
		send_sample(16'd3001, 16'h7FFE, 16'd31, 32'h0000_0032, 1'b0);
		send_sample(16'hABCD, 16'hC000, 16'h5A5A, 32'h0000_0033, 1'b0);

		// random averaging phases, mostly quiet radio
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: avg = 8'd3;
				1: avg = 8'd0;
				2: avg = 8'd4;
				3: avg = 8'($urandom_range(5, 8));
				default: avg = 8'd2;
			endcase
			pick_idling();
			settle_and_configure(avg, 12'd64, 13'd116, $urandom);
			run_random(18, 20);
		end

		// largest averaging count: every sample is held and summed
		pick_idling();
		settle_and_configure(8'd255, 12'd64, 13'd116, 32'h0000_0000);
		run_random(10, 5);
		// a smaller count picks up the held sums on the next quiet sample
		settle_and_configure(8'd3, 12'd64, 13'd116, $urandom);
		run_random(20, 20);

		// direct logging; long flash-side hold backs up the logger
		gap_pct = 25;
		stall_pct = 10;
		settle_and_configure(8'd1, 12'd0, 13'd1, $urandom);
		hold_armed <= 1'b1;
		run_random(40, 10);

		// direct logging, no idling
		gap_pct = 0;
		stall_pct = 0;
		settle_and_configure(8'd1, 12'd4095, 13'd4096, 32'hFFFF_FFFF);
		run_random(30, 10);

		wait_drained();
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
`default_nettype wire

// ===== files.f =====
+incdir+rtl/core
rtl/core/aflr_pkg.sv
rtl/core/aflr_div_lane.sv
rtl/core/averaging_flash_ring_logger_core.sv
sim/flash_log_monitor.sv
sim/testbench.sv
